@@ sv/ultrasonic_echo_distance_average_core_defines.svh @@
// Assertion macros shared by the ultrasonic echo distance checker.
`ifndef ULTRASONIC_ECHO_DISTANCE_AVERAGE_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_DISTANCE_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define UED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ued check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define UED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ued check failed");

`endif

@@ sv/ued_pkg.sv @@
// Shared types and constants of the ultrasonic echo distance averaging core.
package ued_pkg;

    // Default build parameters
    localparam int CHANNELS_DEF   = 4;
    localparam int WINDOW_LEN_DEF = 10;
    localparam int MAX_CH         = 4;

    // Field widths
    localparam int WRAPS_W = 6;
    localparam int TICKS_W = 16;
    localparam int DIST_W  = 16;
    localparam int ECHO_W  = WRAPS_W + TICKS_W;

    // Stream bus layout
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = MAX_CH * DIST_W;
    localparam int VALID_LSB = 0;
    localparam int WRAPS_LSB = VALID_LSB + MAX_CH;
    localparam int TICKS_LSB = WRAPS_LSB + MAX_CH * WRAPS_W;

    // Echo time to millimetres: floor(t * 17 / 100), saturated at 16 bits.
    // Times at or above this value give 65535 mm or more.
    localparam logic [ECHO_W-1:0] ECHO_SAT_TIME = 22'd385506;
    // Width of t * 17 below saturation
    localparam int PROD_W = 23;
    // floor(x / 100) = (x * MM_RECIP) >> MM_SHIFT for every x below 2^23
    localparam int MM_SHIFT   = 30;
    localparam int MM_RECIP_W = 24;
    localparam logic [MM_RECIP_W-1:0] MM_RECIP = 24'd10737419;

    // Pipeline advance strobes handed from the top level to the datapath
    typedef struct packed {
        logic load;     // input transfer into the capture stage
        logic s1_move;  // capture stage into the window stage
        logic s2_move;  // window stage into the output register
    } ued_ctrl_t;

endpackage

@@ sv/ued_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ued_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, hold data while not reading
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ued_echo.sv @@
// Echo capture stages: echo time to saturated millimetres, two register stages.
module ued_echo #(
    parameter int CHANNELS = ued_pkg::CHANNELS_DEF
) (
    input  logic                                         aclk,
    input  ued_pkg::ued_ctrl_t                           ctrl,
    input  logic [CHANNELS-1:0]                          in_valid,
    input  logic [CHANNELS-1:0][ued_pkg::WRAPS_W-1:0]    in_wraps,
    input  logic [CHANNELS-1:0][ued_pkg::TICKS_W-1:0]    in_ticks,
    output logic [CHANNELS-1:0]                          mm_fresh,
    output logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0]     mm_dist
);

    localparam int FULL_W = ued_pkg::PROD_W + ued_pkg::MM_RECIP_W;

    logic [CHANNELS-1:0]                         a_fresh_reg;
    logic [CHANNELS-1:0]                         a_sat_reg;
    logic [CHANNELS-1:0][ued_pkg::PROD_W-1:0]    a_prod_reg;
    logic [CHANNELS-1:0]                         a_sat_next;
    logic [CHANNELS-1:0][ued_pkg::PROD_W-1:0]    a_prod_next;
    logic [CHANNELS-1:0]                         b_fresh_reg;
    logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0]    b_dist_reg;
    logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0]    b_dist_next;

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        logic [ued_pkg::ECHO_W-1:0] echo_time;
        logic [ued_pkg::ECHO_W+4:0] scaled;
        logic [FULL_W-1:0]          quot_full;

        // Scale echo time by 17 with a shift and add
        always_comb begin
            echo_time         = {in_wraps[ch], in_ticks[ch]};
            scaled            = {1'b0, echo_time, 4'b0000} + {5'b00000, echo_time};
            a_sat_next[ch]    = (echo_time >= ued_pkg::ECHO_SAT_TIME);
            a_prod_next[ch]   = scaled[ued_pkg::PROD_W-1:0];
        end

        // Divide by 100 through the reciprocal, saturate long echoes
        always_comb begin
            quot_full = FULL_W'(a_prod_reg[ch]) * FULL_W'(ued_pkg::MM_RECIP);
            if (a_sat_reg[ch]) begin
                b_dist_next[ch] = '1;
            end else begin
                b_dist_next[ch] = quot_full[ued_pkg::MM_SHIFT +: ued_pkg::DIST_W];
            end
        end
    end

    // Capture stage: load on an input transfer
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            a_fresh_reg <= in_valid;
            a_sat_reg   <= a_sat_next;
            a_prod_reg  <= a_prod_next;
        end
    end

    // Conversion stage: advance with the pipeline
    always_ff @(posedge aclk) begin
        if (ctrl.s1_move) begin
            b_fresh_reg <= a_fresh_reg;
            b_dist_reg  <= b_dist_next;
        end
    end

    assign mm_fresh = b_fresh_reg;
    assign mm_dist  = b_dist_reg;

endmodule

@@ sv/ued_window.sv @@
// Window stage: ring memory of past distances, running sums and window means.
module ued_window #(
    parameter int CHANNELS   = ued_pkg::CHANNELS_DEF,
    parameter int WINDOW_LEN = ued_pkg::WINDOW_LEN_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  ued_pkg::ued_ctrl_t                        ctrl,
    input  logic [CHANNELS-1:0]                       mm_fresh,
    input  logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0]  mm_dist,
    output logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0]  avg_mm
);

    localparam int SLOT_W      = $clog2(WINDOW_LEN);
    localparam int ROW_W       = CHANNELS * ued_pkg::DIST_W;
    localparam int SUM_W       = ued_pkg::DIST_W + $clog2(WINDOW_LEN);
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W     = SUM_W + 1;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
    localparam int MEAN_FULL_W = SUM_W + RECIP_W;

    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [WINDOW_LEN-1:0] row_ok_reg;
    logic [SLOT_W-1:0]     s2_slot_reg;
    logic                  s2_ok_reg;
    logic [ROW_W-1:0]      rd_data;
    logic [ROW_W-1:0]      wr_data;

    logic [CHANNELS-1:0][SUM_W-1:0]           sum_reg;
    logic [CHANNELS-1:0][SUM_W-1:0]           sum_next;
    logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0] held_reg;
    logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0] held_next;

    // Advance the shared write position, wrap at the window end
    always_comb begin
        if (slot_reg == SLOT_W'(WINDOW_LEN - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (ctrl.s1_move) begin
            slot_reg <= slot_next;
        end
    end

    // Mark rows once written; an unwritten row reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
        end else if (ctrl.s2_move) begin
            row_ok_reg[s2_slot_reg] <= 1'b1;
        end
    end

    // Carry the slot with the read it issued
    always_ff @(posedge aclk) begin
        if (ctrl.s1_move) begin
            s2_slot_reg <= slot_reg;
            s2_ok_reg   <= row_ok_reg[slot_reg];
        end
    end

    // One row holds the slot of every channel
    ued_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.s2_move),
        .wr_addr (s2_slot_reg),
        .wr_data (wr_data),
        .rd_en   (ctrl.s1_move),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        logic [ued_pkg::DIST_W-1:0] entering;
        logic [ued_pkg::DIST_W-1:0] oldest;
        logic [MEAN_FULL_W-1:0]     mean_full;

        // Swap oldest for newest in the running sum, then divide by the window length
        always_comb begin
            entering     = mm_fresh[ch] ? mm_dist[ch] : held_reg[ch];
            oldest       = s2_ok_reg ? rd_data[ch*ued_pkg::DIST_W +: ued_pkg::DIST_W] : '0;
            sum_next[ch] = sum_reg[ch] - SUM_W'(oldest) + SUM_W'(entering);
            mean_full    = MEAN_FULL_W'(sum_next[ch]) * MEAN_FULL_W'(RECIP);
            held_next[ch] = mean_full[RECIP_SHIFT +: ued_pkg::DIST_W];
            wr_data[ch*ued_pkg::DIST_W +: ued_pkg::DIST_W] = entering;
        end
    end

    // Running sums and held means; the held means double as the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            held_reg <= '0;
        end else if (ctrl.s2_move) begin
            sum_reg  <= sum_next;
            held_reg <= held_next;
        end
    end

    assign avg_mm = held_reg;

endmodule

@@ sv/ultrasonic_echo_distance_average_core.sv @@
// Top level of the four-channel ultrasonic echo distance averaging core.
//
//   Channel | Direction | Payload (lowest bits first)
//   --------+-----------+----------------------------------------------------
//   s_      | in        | valid_a..d, wraps_a..d, ticks_a..d (92 of 96 bits)
//   m_      | out       | dist_a..d (64 bits)
//
// Each transfer is one measurement round; one round is taken every cycle unless m_ stalls.
// m_tvalid rises once the round's transfer on s_ has passed capture (times 17),
// conversion (divide by 100), then the window stage with its running sum.
// The window lives in one RAM row per slot; reset clears the row valid bits, the
// sums and the held means directly, with no clearing pass.
// A stall on m_ holds the result; s_ keeps taking rounds until the stages fill.
module ultrasonic_echo_distance_average_core #(
    parameter int CHANNELS   = ued_pkg::CHANNELS_DEF,
    parameter int WINDOW_LEN = ued_pkg::WINDOW_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // valid_a, valid_b, valid_c, valid_d, wraps_a, wraps_b, wraps_c, wraps_d,
    // ticks_a, ticks_b, ticks_c, ticks_d, zero fill
    input  logic [ued_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // dist_a, dist_b, dist_c, dist_d
    output logic [ued_pkg::M_TDATA_W-1:0] m_tdata
);

    ued_pkg::ued_ctrl_t ctrl;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic [CHANNELS-1:0]                         in_valid;
    logic [CHANNELS-1:0][ued_pkg::WRAPS_W-1:0]   in_wraps;
    logic [CHANNELS-1:0][ued_pkg::TICKS_W-1:0]   in_ticks;
    logic [CHANNELS-1:0]                         mm_fresh;
    logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0]    mm_dist;
    logic [CHANNELS-1:0][ued_pkg::DIST_W-1:0]    avg_mm;

    // Advance each stage when the one after it is free or moving on
    always_comb begin
        ctrl.s2_move = s2_valid_reg && (!out_valid_reg || m_tready);
        ctrl.s1_move = s1_valid_reg && (!s2_valid_reg || ctrl.s2_move);
        s_tready     = !s1_valid_reg || ctrl.s1_move;
        ctrl.load    = s_tvalid && s_tready;
    end

    // Stage occupancy
    always_comb begin
        s1_valid_next  = ctrl.load || (s1_valid_reg && !ctrl.s1_move);
        s2_valid_next  = ctrl.s1_move || (s2_valid_reg && !ctrl.s2_move);
        out_valid_next = ctrl.s2_move || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Unpack the input fields of the channels in use
    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_unpack
        assign in_valid[ch] = s_tdata[ued_pkg::VALID_LSB + ch];
        assign in_wraps[ch] = s_tdata[ued_pkg::WRAPS_LSB + ch*ued_pkg::WRAPS_W +: ued_pkg::WRAPS_W];
        assign in_ticks[ch] = s_tdata[ued_pkg::TICKS_LSB + ch*ued_pkg::TICKS_W +: ued_pkg::TICKS_W];
    end

    ued_echo #(
        .CHANNELS (CHANNELS)
    ) u_echo (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .in_valid (in_valid),
        .in_wraps (in_wraps),
        .in_ticks (in_ticks),
        .mm_fresh (mm_fresh),
        .mm_dist  (mm_dist)
    );

    ued_window #(
        .CHANNELS   (CHANNELS),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .mm_fresh (mm_fresh),
        .mm_dist  (mm_dist),
        .avg_mm   (avg_mm)
    );

    // Pack results; channels not built read as zero
    for (genvar ch = 0; ch < ued_pkg::MAX_CH; ch++) begin : g_pack
        if (ch < CHANNELS) begin : g_used
            assign m_tdata[ch*ued_pkg::DIST_W +: ued_pkg::DIST_W] = avg_mm[ch];
        end else begin : g_unused
            assign m_tdata[ch*ued_pkg::DIST_W +: ued_pkg::DIST_W] = '0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ sv/ued_checker.sv @@
// Port-level checker of the ultrasonic echo distance averaging core, with its bind.
`include "ultrasonic_echo_distance_average_core_defines.svh"

module ued_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ued_pkg::M_TDATA_W-1:0] m_tdata
);

    logic s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    // Hold a stalled result
    `UED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Keep taking rounds whenever the output register is free or draining
    `UED_ASSERT_NOW(a_in_open, !m_tvalid || m_tready, s_tready)

    // Drain the pipeline after free flow on m_ with no new rounds taken
    `UED_ASSERT_NOW(a_drain, $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3) && !$past(s_xfer, 1) && !$past(s_xfer, 2) && !$past(s_xfer, 3), !m_tvalid)

endmodule

bind ultrasonic_echo_distance_average_core ued_checker u_ued_checker (.*);
